@@ design/cbm_pkg.sv @@
// Shared types and constants of the cartridge bank mapper.
package cbm_pkg;

    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int ROM_BASE_W = 22;
    localparam int BANK_W     = 8;
    localparam int HIGH_W     = 2;
    localparam int RAM_BANK_W = 2;
    localparam int RAM_BASE_W = 15;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 22;

    localparam int ROM_SHIFT  = 14;
    localparam int HIGH_SHIFT = 19;
    localparam int BANK_HIGH_POS = 5;
    localparam int RAM_SHIFT  = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_ROM_ADDR_MASK = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ROM_BANK  = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RAM_BANK  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RAM_BANKING   = 8'd3;

    localparam logic [DATA_W-1:0] RAM_EN_KEY = 8'h0A;

    localparam logic [ROM_BASE_W-1:0] RST_ROM_ADDR_MASK = 22'h3FFFFF;
    localparam logic [BANK_W-1:0]     RST_MAX_ROM_BANK  = 8'd255;
    localparam logic [RAM_BANK_W-1:0] RST_MAX_RAM_BANK  = 2'd3;
    localparam logic                  RST_RAM_BANKING   = 1'b0;

    localparam logic [BANK_W-1:0]     RST_BANK_LOW = 8'd1;
    localparam logic [BANK_W-1:0]     RST_ROM_BANK = 8'd1;
    localparam logic [ROM_BASE_W-1:0] RST_ROM_BASE = 22'h004000;

    typedef enum logic [2:0] {
        REGION_RAM_EN,
        REGION_ROM_BANK,
        REGION_HIGH,
        REGION_MODE,
        REGION_PASS
    } cbm_region_t;

    typedef struct packed {
        logic                  ram_en;
        logic [BANK_W-1:0]     bank_low;
        logic [HIGH_W-1:0]     bank_high;
        logic                  mode;
        logic [BANK_W-1:0]     rom_page;
        logic [ROM_BASE_W-1:0] rom_base;
        logic [RAM_BANK_W-1:0] ram_page;
    } cbm_state_t;

    typedef struct packed {
        logic [ROM_BASE_W-1:0] rom_addr_mask;
        logic [BANK_W-1:0]     max_rom_bank;
        logic [RAM_BANK_W-1:0] max_ram_bank;
        logic                  ram_banking;
    } cbm_cfg_t;

endpackage

@@ design/cbm_update.sv @@
// Next mapper state for one CPU write word.
module cbm_update (
    input  cbm_pkg::cbm_state_t              cur,
    input  cbm_pkg::cbm_cfg_t                cfg,
    input  logic [cbm_pkg::ADDR_W-1:0]       bus_address,
    input  logic [cbm_pkg::DATA_W-1:0]       bus_data,
    output cbm_pkg::cbm_state_t              nxt,
    output logic                             pass
);
    import cbm_pkg::*;

    cbm_region_t           region;
    logic [DATA_W-1:0]     data_fix;
    logic [BANK_W-1:0]     bank_low_sel;
    logic [HIGH_W-1:0]     bank_high_sel;
    logic [BANK_W-1:0]     combo_bank;
    logic [ROM_BASE_W-1:0] combo_base;
    logic [ROM_BASE_W-1:0] direct_base;
    logic [BANK_W-1:0]     high_check;
    logic [RAM_BANK_W-1:0] ram_sel;

    always_comb
    begin
        if (bus_address[ADDR_W-1])
        begin
            region = REGION_PASS;
        end
        else
        begin
            case (bus_address[ADDR_W-2:ADDR_W-3])
                2'd0:    region = REGION_RAM_EN;
                2'd1:    region = REGION_ROM_BANK;
                2'd2:    region = REGION_HIGH;
                default: region = REGION_MODE;
            endcase
        end
    end

    assign data_fix   = (bus_data == '0) ? DATA_W'(1) : bus_data;
    assign high_check = {1'b0, bus_data[HIGH_W-1:0], 5'b0} | cur.bank_low;

    // combined banking uses whichever half this word updates
    always_comb
    begin
        bank_low_sel  = cur.bank_low;
        bank_high_sel = cur.bank_high;
        if (region == REGION_ROM_BANK)
        begin
            bank_low_sel = data_fix;
        end
        if (region == REGION_HIGH)
        begin
            bank_high_sel = bus_data[HIGH_W-1:0];
        end
    end

    assign combo_bank  = bank_low_sel | BANK_W'({bank_high_sel, 5'b0});
    assign combo_base  = ({bank_low_sel, 14'b0} | {1'b0, bank_high_sel, 19'b0})
                         & cfg.rom_addr_mask;
    assign direct_base = {data_fix, 14'b0} & cfg.rom_addr_mask;

    always_comb
    begin
        ram_sel = bus_data[RAM_BANK_W-1:0];
        if (ram_sel > cfg.max_ram_bank)
        begin
            ram_sel = ram_sel & cfg.max_ram_bank;
        end
    end

    always_comb
    begin
        nxt  = cur;
        pass = 1'b0;
        case (region)
            REGION_RAM_EN:
            begin
                nxt.ram_en = ((bus_data & RAM_EN_KEY) == RAM_EN_KEY);
            end
            REGION_ROM_BANK:
            begin
                if (!cur.mode)
                begin
                    nxt.bank_low = data_fix;
                    nxt.rom_page = combo_bank;
                    nxt.rom_base = combo_base;
                end
                else
                begin
                    nxt.rom_page = data_fix;
                    nxt.rom_base = direct_base;
                end
            end
            REGION_HIGH:
            begin
                if (!cur.mode)
                begin
                    if (high_check <= cfg.max_rom_bank)
                    begin
                        nxt.bank_high = bus_data[HIGH_W-1:0];
                        nxt.rom_page  = combo_bank;
                        nxt.rom_base  = combo_base;
                    end
                end
                else if (cfg.ram_banking)
                begin
                    nxt.ram_page = ram_sel;
                end
            end
            REGION_MODE:
            begin
                nxt.mode = bus_data[0];
            end
            default:
            begin
                pass = 1'b1;
            end
        endcase
    end

endmodule

@@ design/cartridge_bank_mapper.sv @@
// Cartridge bank mapper top level: config registers, mapper state, result register.
//
// Each accepted write word updates the mapper state in the cycle it is taken,
// and its mapping word appears on the output in the next cycle. One word per
// cycle is accepted as long as the output side takes results; the only wait
// comes from a stalled output register, which holds input ready low. Config
// writes are always accepted.
module cartridge_bank_mapper (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [cbm_pkg::ADDR_W-1:0]         bus_address,
    input  logic [cbm_pkg::DATA_W-1:0]         bus_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               ram_enabled,
    output logic                               banking_mode,
    output logic [cbm_pkg::BANK_W-1:0]         current_rom_bank,
    output logic [cbm_pkg::ROM_BASE_W-1:0]     rom_window_base,
    output logic [cbm_pkg::RAM_BANK_W-1:0]     current_ram_bank,
    output logic [cbm_pkg::RAM_BASE_W-1:0]     ram_window_base,
    output logic                               passthrough_write,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [cbm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import cbm_pkg::*;

    cbm_cfg_t   cfg_reg;
    cbm_state_t state_reg;
    cbm_state_t state_next;
    logic       pass_reg;
    logic       pass_next;
    logic       out_valid_reg;
    logic       in_fire;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rom_addr_mask <= RST_ROM_ADDR_MASK;
            cfg_reg.max_rom_bank  <= RST_MAX_ROM_BANK;
            cfg_reg.max_ram_bank  <= RST_MAX_RAM_BANK;
            cfg_reg.ram_banking   <= RST_RAM_BANKING;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ROM_ADDR_MASK: cfg_reg.rom_addr_mask <= cfg_data[ROM_BASE_W-1:0];
                CFG_MAX_ROM_BANK:  cfg_reg.max_rom_bank  <= cfg_data[BANK_W-1:0];
                CFG_MAX_RAM_BANK:  cfg_reg.max_ram_bank  <= cfg_data[RAM_BANK_W-1:0];
                CFG_RAM_BANKING:   cfg_reg.ram_banking   <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    cbm_update u_update (
        .cur         (state_reg),
        .cfg         (cfg_reg),
        .bus_address (bus_address),
        .bus_data    (bus_data),
        .nxt         (state_next),
        .pass        (pass_next)
    );

    // state doubles as the result word: it cannot move while a result is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.ram_en    <= 1'b0;
            state_reg.bank_low  <= RST_BANK_LOW;
            state_reg.bank_high <= '0;
            state_reg.mode      <= 1'b0;
            state_reg.rom_page  <= RST_ROM_BANK;
            state_reg.rom_base  <= RST_ROM_BASE;
            state_reg.ram_page  <= '0;
            pass_reg            <= 1'b0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                state_reg <= state_next;
                pass_reg  <= pass_next;
            end
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign ram_enabled       = state_reg.ram_en;
    assign banking_mode      = state_reg.mode;
    assign current_rom_bank  = state_reg.rom_page;
    assign rom_window_base   = state_reg.rom_base;
    assign current_ram_bank  = state_reg.ram_page;
    assign ram_window_base   = RAM_BASE_W'({state_reg.ram_page, 13'b0});
    assign passthrough_write = pass_reg;

    a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        current_rom_bank != '0)
        else $error("ROM bank zero");

    a_pass_flag: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && bus_address[ADDR_W-1] |=> out_valid && passthrough_write)
        else $error("pass-through flag missing");

    a_pass_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && bus_address[ADDR_W-1] |=> $stable(state_reg))
        else $error("pass-through write changed mapper state");

    a_no_fire_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(state_reg) && out_valid)
        else $error("state moved under stalled result");

endmodule

@@ verif/tb_cartridge_bank_mapper.sv @@
// Testbench for the cartridge bank mapper: mapping scoreboard plus driving tasks.
`timescale 1ns / 100ps

package cbm_check_pkg;
    import cbm_pkg::*;

    localparam logic [ADDR_W-1:0] ROM_BANK_START = 16'h2000;
    localparam logic [ADDR_W-1:0] HIGH_START     = 16'h4000;
    localparam logic [ADDR_W-1:0] MODE_START     = 16'h6000;
    localparam logic [ADDR_W-1:0] PASS_START     = 16'h8000;
    localparam int                REGION_SPAN    = 16'h1FFF;
    localparam int                MAX_REPORTS    = 200;

    typedef struct packed {
        logic                  ram_enabled;
        logic                  banking_mode;
        logic [BANK_W-1:0]     rom_page;
        logic [ROM_BASE_W-1:0] rom_base;
        logic [RAM_BANK_W-1:0] ram_page;
        logic [RAM_BASE_W-1:0] ram_base;
        logic                  passthrough;
    } mapping_t;

    class mapping_scoreboard;
        cbm_cfg_t   regs;
        cbm_state_t mapper;
        mapping_t   mapping_q[$];
        int         n_checked;
        int         n_errors;

        function new();
            regs.rom_addr_mask = RST_ROM_ADDR_MASK;
            regs.max_rom_bank  = RST_MAX_ROM_BANK;
            regs.max_ram_bank  = RST_MAX_RAM_BANK;
            regs.ram_banking   = RST_RAM_BANKING;
            mapper.ram_en      = 1'b0;
            mapper.bank_low    = RST_BANK_LOW;
            mapper.bank_high   = '0;
            mapper.mode        = 1'b0;
            mapper.rom_page    = RST_ROM_BANK;
            mapper.rom_base    = RST_ROM_BASE;
            mapper.ram_page    = '0;
            n_checked = 0;
            n_errors  = 0;
        endfunction

        function int pending();
            return mapping_q.size();
        endfunction

        function void apply_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_ROM_ADDR_MASK: regs.rom_addr_mask = value[ROM_BASE_W-1:0];
                CFG_MAX_ROM_BANK:  regs.max_rom_bank  = value[BANK_W-1:0];
                CFG_MAX_RAM_BANK:  regs.max_ram_bank  = value[RAM_BANK_W-1:0];
                CFG_RAM_BANKING:   regs.ram_banking   = value[0];
                default: ;
            endcase
        endfunction

        function void fold_rom_bank();
            mapper.rom_page = mapper.bank_low | (BANK_W'(mapper.bank_high) << BANK_HIGH_POS);
            mapper.rom_base = ((ROM_BASE_W'(mapper.bank_low) << ROM_SHIFT)
                             | (ROM_BASE_W'(mapper.bank_high) << HIGH_SHIFT))
                             & regs.rom_addr_mask;
        endfunction

        function void note_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
            cbm_region_t           region;
            mapping_t              m;
            logic [DATA_W-1:0]     d;
            logic [RAM_BANK_W-1:0] b;
            logic                  pass;
            pass = 1'b0;
            d    = data;
            if (addr < ROM_BANK_START)
                region = REGION_RAM_EN;
            else if (addr < HIGH_START)
                region = REGION_ROM_BANK;
            else if (addr < MODE_START)
                region = REGION_HIGH;
            else if (addr < PASS_START)
                region = REGION_MODE;
            else
                region = REGION_PASS;
            case (region)
                REGION_RAM_EN:
                    mapper.ram_en = ((data & RAM_EN_KEY) == RAM_EN_KEY);
                REGION_ROM_BANK:
                begin
                    if (d == '0)
                        d = 8'd1;
                    if (!mapper.mode)
                    begin
                        mapper.bank_low = d;
                        fold_rom_bank();
                    end
                    else
                    begin
                        mapper.rom_page = d;
                        mapper.rom_base = (ROM_BASE_W'(d) << ROM_SHIFT) & regs.rom_addr_mask;
                    end
                end
                REGION_HIGH:
                begin
                    if (!mapper.mode)
                    begin
                        if (((int'(data[1:0]) << BANK_HIGH_POS) | int'(mapper.bank_low))
                            <= int'(regs.max_rom_bank))
                        begin
                            mapper.bank_high = data[1:0];
                            fold_rom_bank();
                        end
                    end
                    else if (regs.ram_banking)
                    begin
                        b = data[1:0];
                        if (b > regs.max_ram_bank)
                            b &= regs.max_ram_bank;
                        mapper.ram_page = b;
                    end
                end
                REGION_MODE:
                    mapper.mode = data[0];
                default:
                    pass = 1'b1;
            endcase
            m.ram_enabled  = mapper.ram_en;
            m.banking_mode = mapper.mode;
            m.rom_page     = mapper.rom_page;
            m.rom_base     = mapper.rom_base;
            m.ram_page     = mapper.ram_page;
            m.ram_base     = RAM_BASE_W'(mapper.ram_page) << RAM_SHIFT;
            m.passthrough  = pass;
            mapping_q.push_back(m);
        endfunction

        function void field_ok(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t mismatch %s: expected 0x%0h, actual 0x%0h",
                             $time, name, exp_v, act_v);
            end
        endfunction

        function void check_mapping(mapping_t act);
            mapping_t exp_m;
            if (mapping_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t unexpected result word, none pending: actual 0x%0h",
                             $time, act);
                return;
            end
            exp_m = mapping_q.pop_front();
            n_checked++;
            field_ok("ram_enabled",       32'(exp_m.ram_enabled),  32'(act.ram_enabled));
            field_ok("banking_mode",      32'(exp_m.banking_mode), 32'(act.banking_mode));
            field_ok("current_rom_bank",  32'(exp_m.rom_page),     32'(act.rom_page));
            field_ok("rom_window_base",   32'(exp_m.rom_base),     32'(act.rom_base));
            field_ok("current_ram_bank",  32'(exp_m.ram_page),     32'(act.ram_page));
            field_ok("ram_window_base",   32'(exp_m.ram_base),     32'(act.ram_base));
            field_ok("passthrough_write", 32'(exp_m.passthrough),  32'(act.passthrough));
        endfunction
    endclass
endpackage

module tb_cartridge_bank_mapper;
    import cbm_pkg::*;
    import cbm_check_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD      = 80;
    localparam int PHASES         = 6;
    localparam int PHASE_WORDS    = 250;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [ADDR_W-1:0]     bus_address = '0;
    logic [DATA_W-1:0]     bus_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  ram_enabled;
    logic                  banking_mode;
    logic [BANK_W-1:0]     current_rom_bank;
    logic [ROM_BASE_W-1:0] rom_window_base;
    logic [RAM_BANK_W-1:0] current_ram_bank;
    logic [RAM_BASE_W-1:0] ram_window_base;
    logic                  passthrough_write;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    mapping_scoreboard sb;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  tx_burst = 1'b0;
    bit  rx_burst = 1'b0;
    bit  long_hold_req = 1'b0;
    int  n_sent = 0;
    int  n_cfg = 0;
    int  n_long_holds = 0;

    cartridge_bank_mapper uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .bus_address       (bus_address),
        .bus_data          (bus_data),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .ram_enabled       (ram_enabled),
        .banking_mode      (banking_mode),
        .current_rom_bank  (current_rom_bank),
        .rom_window_base   (rom_window_base),
        .current_ram_bank  (current_ram_bank),
        .ram_window_base   (ram_window_base),
        .passthrough_write (passthrough_write),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int pick_gap();
        if ($urandom_range(0, 9) < 8)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // monitor: checks first, then notes; a result never belongs to a word taken this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_mapping(mapping_t'({ram_enabled, banking_mode, current_rom_bank,
                                             rom_window_base, current_ram_bank,
                                             ram_window_base, passthrough_write}));
            if (in_valid && in_ready)
                sb.note_write(bus_address, bus_data);
            if (cfg_valid && cfg_ready)
                sb.apply_cfg(cfg_index, cfg_data);
        end
    end

    // result side
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            stall_left = LONG_HOLD;
            n_long_holds++;
            out_ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!rx_burst && $urandom_range(0, 2) == 0)
                stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t watchdog: no handshake for %0d cycles", $time, idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic send_word(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        int gap;
        gap = 0;
        if (!tx_burst && $urandom_range(0, 2) == 0)
            gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        bus_address <= addr;
        bus_data    <= data;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic random_word();
        int                r;
        logic [ADDR_W-1:0] a;
        logic [DATA_W-1:0] d;
        r = $urandom_range(0, 9);
        if (r < 2)
            a = 16'($urandom_range(0, REGION_SPAN));
        else if (r < 5)
            a = ROM_BANK_START + 16'($urandom_range(0, REGION_SPAN));
        else if (r < 8)
            a = HIGH_START + 16'($urandom_range(0, REGION_SPAN));
        else if (r < 9)
            a = MODE_START + 16'($urandom_range(0, REGION_SPAN));
        else
            a = PASS_START + 16'($urandom_range(0, 16'h7FFF));
        d = ($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
        send_word(a, d);
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        n_cfg++;
    endtask

    task automatic load_config(logic [ROM_BASE_W-1:0] mask, logic [BANK_W-1:0] max_rom,
                               logic [RAM_BANK_W-1:0] max_ram, logic allow);
        set_reg(CFG_ROM_ADDR_MASK, CFG_DATA_W'(mask));
        set_reg(CFG_MAX_ROM_BANK,  CFG_DATA_W'(max_rom));
        set_reg(CFG_MAX_RAM_BANK,  CFG_DATA_W'(max_ram));
        set_reg(CFG_RAM_BANKING,   CFG_DATA_W'(allow));
        // unused index, must leave everything alone
        set_reg(8'($urandom_range(4, 255)), 22'($urandom()));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic end_phase();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    initial
    begin
        logic [ROM_BASE_W-1:0] mask;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: enable key, zero bank, extremes, pass-through, mode 1 without RAM banking
        send_word(16'h0000, 8'h0A);
        send_word(16'h1FFF, 8'h05);
        send_word(16'h0123, 8'hFF);
        send_word(16'h2000, 8'h00);
        send_word(16'h3FFF, 8'hFF);
        send_word(16'h4000, 8'h03);
        send_word(16'h8000, 8'h55);
        send_word(16'hFFFF, 8'hAA);
        send_word(16'h6000, 8'h01);
        send_word(16'h5FFF, 8'h02);
        send_word(16'h3000, 8'h00);
        send_word(16'h2001, 8'hC0);
        send_word(16'h7FFF, 8'hFE);
        end_phase();

        // all-zero limits: high bits rejected, RAM bank clamped to zero
        load_config('0, '0, '0, 1'b1);
        cfg_valid <= 1'b1;
        cfg_index <= 8'd255;
        cfg_data  <= 22'h3FFFFF;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        n_cfg++;
        cfg_valid <= 1'b0;
        @(posedge clk);
        send_word(16'h4000, 8'h01);
        send_word(16'h2000, 8'h01);
        send_word(16'h6000, 8'h01);
        send_word(16'h4000, 8'h03);
        end_phase();

        load_config(22'h3FFFFF, 8'h40, 2'd1, 1'b1);
        send_word(16'h4000, 8'h02);
        send_word(16'h4000, 8'h03);
        send_word(16'h6000, 8'h00);
        send_word(16'h2000, 8'h21);
        send_word(16'h4000, 8'h01);
        send_word(16'h4000, 8'h02);
        end_phase();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                load_config(22'h3FFFFF, 8'hFF, 2'd3, 1'b1);
            else if (p == 1)
                load_config('0, '0, '0, 1'b0);
            else
            begin
                if ($urandom_range(0, 3) == 0)
                    mask = 22'($urandom());
                else
                    mask = 22'((32'd1 << $urandom_range(15, 22)) - 1);
                load_config(mask, 8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)),
                            1'($urandom_range(0, 1)));
            end
            if (p == 0)
            begin
                // output held off while input keeps coming: block must back up
                tx_burst = 1'b1;
                long_hold_req = 1'b1;
            end
            for (int i = 0; i < PHASE_WORDS; i++)
            begin
                if (i % 64 == 0 && !(p == 0 && i < 128))
                begin
                    tx_burst = ($urandom_range(0, 3) == 0);
                    rx_burst = ($urandom_range(0, 3) == 0);
                end
                random_word();
            end
            end_phase();
        end

        repeat (8) @(posedge clk);
        $display("Summary: %0d bus words over %0d setting phases, %0d mapping words checked,",
                 n_sent, PHASES + 3, sb.n_checked);
        $display("         %0d config writes, %0d long output hold(s), %0d mismatches",
                 n_cfg, n_long_holds, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
